/* sv/nlqt_pkg.sv */
// Package: types and constants shared by the neighbour link quality table.
package nlqt_pkg;
	localparam int TABLE_DEPTH   = 16;
	localparam int HISTORY_DEPTH = 10;
	localparam int IDX_W  = $clog2(TABLE_DEPTH);
	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
	localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int HIST_ENTRIES = TABLE_DEPTH * HISTORY_DEPTH;
	localparam int HADDR_W = $clog2(HIST_ENTRIES);

	typedef enum logic [1:0] {
		KIND_BEACON = 2'd0,
		KIND_PING   = 2'd1,
		KIND_CHOOSE = 2'd2,
		KIND_READ   = 2'd3
	} kind_t;

	typedef struct packed {
		logic        neg;
		logic [7:0]  whole;
		logic [13:0] frac;
	} sample_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] sender_addr;
		logic [7:0]  link_quality;
		sample_t     smp;
		logic [3:0]  entry_index;
		logic [3:0]  history_slot;
	} req_t;

	typedef struct packed {
		logic        address_hit;
		logic        entry_added;
		logic        send_pong;
		logic [4:0]  neighbor_count;
		logic        best_valid;
		logic [15:0] best_addr;
		logic [7:0]  best_quality;
		sample_t     rd;
	} rsp_t;

	// Payload of a transaction on the input channel.
	typedef struct packed {
		logic [1:0]        kind;
		logic [15:0]       sender_addr;
		logic [7:0]        link_quality;
		logic              temp_negative;
		logic signed [7:0] temp_whole;
		logic [13:0]       temp_fraction;
		logic [3:0]        entry_index;
		logic [3:0]        history_slot;
	} in_t;

	// Payload of a transaction on the output channel.
	typedef struct packed {
		logic              address_hit;
		logic              entry_added;
		logic              send_pong;
		logic [4:0]        neighbor_count;
		logic              best_valid;
		logic [15:0]       best_addr;
		logic [7:0]        best_quality;
		logic              read_negative;
		logic signed [7:0] read_whole;
		logic [13:0]       read_fraction;
	} out_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CLEAR, ST_SCAN, ST_DECIDE, ST_SHIFT_RD, ST_SHIFT_WR,
		ST_PUSH, ST_READ, ST_READ_WAIT, ST_DONE
	} state_t;
endpackage

/* sv/nlqt_stream_if.sv */
// Interface: valid/ready channel carrying one payload.
interface nlqt_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* sv/nlqt_front.sv */
// Front end: accepts requests, repacks them and queues them for the engine.
module nlqt_front import nlqt_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	nlqt_stream_if.sink in,
	output logic   q_valid,
	output req_t   q_data,
	input  logic   q_pop
);
	req_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push;
	req_t       r;

	always_comb begin
		r = '0;
		r.kind         = in.data.kind;
		r.sender_addr  = in.data.sender_addr;
		r.link_quality = in.data.link_quality;
		r.smp.neg      = in.data.temp_negative;
		r.smp.whole    = in.data.temp_whole;
		r.smp.frac     = in.data.temp_fraction;
		r.entry_index  = in.data.entry_index;
		r.history_slot = in.data.history_slot;
	end

	assign in.ready = (cnt_q != 2'd2);
	assign push     = in.valid && in.ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_data   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule

/* sv/nlqt_back.sv */
// Back end: sequencer over the neighbour table and the history memory.
module nlqt_back import nlqt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	input  req_t q_data,
	output logic q_pop,
	nlqt_stream_if.source out
);
	logic [15:0]      addr_q [TABLE_DEPTH];
	logic [7:0]       qual_q [TABLE_DEPTH];
	logic [CNT_W-1:0] count_q;
	sample_t          hist_mem [HIST_ENTRIES];

	state_t state_q, state_d;
	req_t   req_q;
	logic [CNT_W-1:0]   i_q;
	logic [HADDR_W-1:0] clr_q;
	logic [SLOT_W-1:0]  slot_q;
	logic               hit_q;
	logic [IDX_W-1:0]   hidx_q;
	logic [7:0]         top_q;
	logic [15:0]        taddr_q;
	sample_t            rdata_q;
	rsp_t               rsp_q;
	logic               ovalid_q;

	logic [IDX_W-1:0]   ii;
	logic               scan_end;
	logic [11:0]        wsum;
	logic [7:0]         ewma;
	logic               mem_we;
	logic [HADDR_W-1:0] mem_wa, mem_ra;
	sample_t            mem_wd;
	logic               rd_ok;
	logic [HADDR_W-1:0] base;
	logic               add_new;
	rsp_t               dec_rsp;
	rsp_t               done_rsp;

	assign ii       = i_q[IDX_W-1:0];
	assign scan_end = (i_q >= count_q);
	assign base     = HADDR_W'(hidx_q) * HADDR_W'(HISTORY_DEPTH);
	assign wsum     = 12'(qual_q[hidx_q]) * 12'd7 + 12'(req_q.link_quality) * 12'd3;
	// Quotient by ten through the reciprocal 6554/65536, exact below 16384.
	assign ewma     = 8'((25'(wsum) * 25'd6554) >> 16);
	assign rd_ok    = (32'(req_q.entry_index) < TABLE_DEPTH)
	               && (32'(req_q.history_slot) < HISTORY_DEPTH);
	assign add_new  = (req_q.kind == KIND_BEACON) && !hit_q
	               && (count_q < CNT_W'(TABLE_DEPTH));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR:    if (clr_q == HADDR_W'(HIST_ENTRIES - 1)) state_d = ST_IDLE;
			ST_IDLE:     if (q_valid && !ovalid_q) begin
				state_d = (q_data.kind == KIND_READ) ? ST_READ : ST_SCAN;
			end
			ST_SCAN:     if (scan_end || (hit_q && req_q.kind != KIND_CHOOSE))
				state_d = ST_DECIDE;
			ST_DECIDE:   state_d = (req_q.kind == KIND_PING && hit_q && HISTORY_DEPTH > 1)
				? ST_SHIFT_RD : (req_q.kind == KIND_PING && hit_q) ? ST_PUSH : ST_DONE;
			ST_SHIFT_RD: state_d = ST_SHIFT_WR;
			ST_SHIFT_WR: state_d = (slot_q == SLOT_W'(1)) ? ST_PUSH : ST_SHIFT_RD;
			ST_PUSH:     state_d = ST_DONE;
			ST_READ:     state_d = ST_READ_WAIT;
			ST_READ_WAIT: state_d = ST_DONE;
			ST_DONE:     state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		q_pop  = (state_q == ST_IDLE) && q_valid && !ovalid_q;
		mem_we = 1'b0;
		mem_wa = base + HADDR_W'(slot_q);
		mem_wd = rdata_q;
		mem_ra = base + HADDR_W'(slot_q) - HADDR_W'(1);
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1; mem_wa = clr_q; mem_wd = '0;
			end
			ST_SHIFT_WR: mem_we = 1'b1;
			ST_PUSH: begin
				mem_we = 1'b1; mem_wa = base; mem_wd = req_q.smp;
			end
			ST_READ, ST_READ_WAIT: mem_ra = HADDR_W'(req_q.entry_index)
				* HADDR_W'(HISTORY_DEPTH) + HADDR_W'(req_q.history_slot);
			default: ;
		endcase
	end

	always_comb begin
		dec_rsp = '0;
		dec_rsp.address_hit  = hit_q && (req_q.kind != KIND_CHOOSE);
		dec_rsp.send_pong    = (req_q.kind == KIND_PING);
		dec_rsp.best_valid   = (req_q.kind == KIND_CHOOSE) && (top_q != 8'd0);
		dec_rsp.best_addr    = ((req_q.kind == KIND_CHOOSE) && (top_q != 8'd0))
			? taddr_q : 16'd0;
		dec_rsp.best_quality = (req_q.kind == KIND_CHOOSE) ? top_q : 8'd0;
		dec_rsp.entry_added  = add_new;
		done_rsp = rsp_q;
		done_rsp.neighbor_count = 5'(count_q);
		if (req_q.kind == KIND_READ) done_rsp.rd = rd_ok ? rdata_q : '0;
	end

	always_ff @(posedge clk) begin
		if (mem_we) hist_mem[mem_wa] <= mem_wd;
		rdata_q <= hist_mem[mem_ra];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DECIDE && req_q.kind == KIND_BEACON) begin
			if (hit_q) qual_q[hidx_q] <= ewma;
			else if (count_q < CNT_W'(TABLE_DEPTH)) begin
				addr_q[count_q[IDX_W-1:0]] <= req_q.sender_addr;
				qual_q[count_q[IDX_W-1:0]] <= req_q.link_quality;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR; clr_q <= '0; count_q <= '0; ovalid_q <= 1'b0;
			i_q <= '0; hit_q <= 1'b0; slot_q <= '0;
			hidx_q <= '0; top_q <= '0; taddr_q <= '0; rsp_q <= '0;
		end else begin
			state_q <= state_d;
			if (out.valid && out.ready) ovalid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: clr_q <= clr_q + HADDR_W'(1);
				ST_IDLE: if (q_pop) begin
					i_q <= '0; hit_q <= 1'b0; top_q <= '0; taddr_q <= '0;
					slot_q <= SLOT_W'(HISTORY_DEPTH - 1);
				end
				ST_SCAN: if (!scan_end) begin
					i_q <= i_q + CNT_W'(1);
					if (req_q.kind == KIND_CHOOSE) begin
						if (qual_q[ii] > top_q) begin
							top_q <= qual_q[ii]; taddr_q <= addr_q[ii];
						end
					end else if (!hit_q && addr_q[ii] == req_q.sender_addr) begin
						hit_q <= 1'b1; hidx_q <= ii;
					end
				end
				ST_DECIDE: begin
					rsp_q <= dec_rsp;
					if (add_new) count_q <= count_q + CNT_W'(1);
				end
				ST_SHIFT_WR: slot_q <= slot_q - SLOT_W'(1);
				ST_READ_WAIT: begin
					rsp_q <= '0;
				end
				ST_DONE: begin
					rsp_q <= done_rsp;
					ovalid_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) req_q <= q_data;
	end

	assign out.valid = ovalid_q;
	always_comb begin
		out.data = '0;
		out.data.address_hit    = rsp_q.address_hit;
		out.data.entry_added    = rsp_q.entry_added;
		out.data.send_pong      = rsp_q.send_pong;
		out.data.neighbor_count = rsp_q.neighbor_count;
		out.data.best_valid     = rsp_q.best_valid;
		out.data.best_addr      = rsp_q.best_addr;
		out.data.best_quality   = rsp_q.best_quality;
		out.data.read_negative  = rsp_q.rd.neg;
		out.data.read_whole     = rsp_q.rd.whole;
		out.data.read_fraction  = rsp_q.rd.frac;
	end
endmodule

/* sv/neighbor_link_quality_table.sv */
// Top level of the neighbour link quality table.
// The block keeps up to sixteen radio neighbours, each with a smoothed link quality and a history
// of ten temperature samples. Each transaction on in yields exactly one transaction on out.
// After reset the history memory is cleared one entry a cycle, and the engine takes no request
// meanwhile, though the queue still accepts them. A beacon, ping or choose request walks the table
// one entry a cycle; a ping that hits then shifts the history one slot at a time, a read state
// and then a write state for each slot, before the new sample is pushed into slot zero.
// A two-deep request queue lets the next transaction be taken while the engine is busy.
module neighbor_link_quality_table import nlqt_pkg::*; (
	input logic clk,
	input logic arst_n,
	nlqt_stream_if.sink   in,
	nlqt_stream_if.source out
);
	logic q_valid, q_pop;
	req_t q_data;

	nlqt_front u_front (
		.clk, .arst_n, .in,
		.q_valid, .q_data, .q_pop
	);

	nlqt_back u_back (
		.clk, .arst_n,
		.q_valid, .q_data, .q_pop, .out
	);
endmodule
